### design/elhp_pkg.sv
// Shared types, constants and helpers for the Ethernet link header parser.
// Used by elhp_step and ethernet_link_header_parser_top; depends on nothing else.
package elhp_pkg;

    localparam int MAX_HEADER_BYTES_DEF = 2047;
    localparam int HB_W                 = 11;

    typedef enum logic [2:0] {
        PH_ETH,
        PH_FP,
        PH_VLAN,
        PH_PPPOE,
        PH_MPLS,
        PH_MPLS_IP,
        PH_ENCAP,
        PH_DONE
    } phase_t;

    localparam logic [3:0] ERR_OK          = 4'd0;
    localparam logic [3:0] ERR_TRUNC_FP    = 4'd1;
    localparam logic [3:0] ERR_TRUNC_LINK  = 4'd2;
    localparam logic [3:0] ERR_PPPOE_NONIP = 4'd3;
    localparam logic [3:0] ERR_NON_IP      = 4'd4;
    localparam logic [3:0] ERR_MPLS_NO_IP  = 4'd5;
    localparam logic [3:0] ERR_ENCAP_SHORT = 4'd6;
    localparam logic [3:0] ERR_ENCAP_NO_IP = 4'd7;
    localparam logic [3:0] ERR_TOO_LONG    = 4'd8;

    localparam logic [1:0] L3_NONE    = 2'd0;
    localparam logic [1:0] L3_IPV4    = 2'd1;
    localparam logic [1:0] L3_IPV6    = 2'd2;
    localparam logic [1:0] L3_ARP     = 2'd3;

    localparam logic [15:0] ETH_FABRIC  = 16'h8903;
    localparam logic [15:0] ETH_VLAN_Q  = 16'h8100;
    localparam logic [15:0] ETH_VLAN_AD = 16'h9100;
    localparam logic [15:0] ETH_PPPOE   = 16'h8864;
    localparam logic [15:0] ETH_MPLS    = 16'h8847;
    localparam logic [15:0] ETH_IPV4    = 16'h0800;
    localparam logic [15:0] ETH_IPV6    = 16'h86DD;
    localparam logic [15:0] ETH_ARP     = 16'h0806;
    localparam logic [15:0] ETH_RARP    = 16'h8035;
    localparam logic [15:0] PPP_IPV4    = 16'h0021;
    localparam logic [15:0] PPP_IPV6    = 16'h0057;

    localparam logic [3:0] IP_VERSION_4 = 4'd4;
    localparam logic [3:0] IP_VERSION_6 = 4'd6;

    // Per-frame parse context; offset and header start live beside it
    // because their width follows the header length limit.
    typedef struct packed {
        phase_t      phase;
        logic [15:0] field_shift;
        logic [15:0] cur_type;
        logic [11:0] outer_vlan;
        logic [11:0] inner_tag;
        logic [11:0] tag_vid;
        logic        vlan_seen;
        logic [1:0]  proto_kind;
        logic [7:0]  enc_len;
    } frame_state_t;

    typedef struct packed {
        logic [1:0]      l3_kind;
        logic [15:0]     ethertype;
        logic [11:0]     outer_vlan_id;
        logic [11:0]     inner_vid;
        logic [HB_W-1:0] header_bytes;
        logic [3:0]      error_code;
    } result_t;

    localparam frame_state_t FRAME_CLEAR = '{
        phase:       PH_ETH,
        field_shift: 16'h0000,
        cur_type:    16'h0000,
        outer_vlan:  12'h000,
        inner_tag:   12'h000,
        tag_vid:     12'h000,
        vlan_seen:   1'b0,
        proto_kind:  L3_NONE,
        enc_len:     8'h00
    };

    function automatic logic [1:0] version_kind(input logic [3:0] ver);
        logic [1:0] kind;
        kind = L3_NONE;
        if (ver == IP_VERSION_4)
        begin
            kind = L3_IPV4;
        end
        else if (ver == IP_VERSION_6)
        begin
            kind = L3_IPV6;
        end
        return kind;
    endfunction

endpackage

### design/ethernet_link_header_parser_top.sv
// Pipeline: a frame byte accepted on s_axis is held in the input register, parsed
// from there, and its result, if any, loaded into the result register for m_axis.
// Throughput: one byte per cycle while m_axis is not stalled; the single parse step
// between the input register and the result register is the only work on a byte.
// Reset: asynchronous, active low; clears the frame context, empties both
// registers and sets encap_length to zero. Depends on elhp_pkg and elhp_step.
module ethernet_link_header_parser_top
    import elhp_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,       // encap_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tlast,    // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] final_ethertype, [27:16] outer VLAN ID, [39:28] inner VLAN ID,
    // [50:40] header_bytes, [54:51] error_code, [55] zero
    output logic [55:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser     // [1:0] l3_kind
);

    localparam int OFS_W = $clog2(MAX_HEADER_BYTES + 2);

    logic             in_valid_reg;
    logic [7:0]       in_data_reg;
    logic             in_last_reg;
    logic             out_valid_reg;
    result_t          res_reg;
    logic [7:0]       encap_len_reg;
    frame_state_t     frame_reg;
    frame_state_t     frame_next;
    logic [OFS_W-1:0] hdr_start_reg;
    logic [OFS_W-1:0] hdr_start_next;
    logic [OFS_W-1:0] offset_reg;
    logic [OFS_W-1:0] offset_next;
    logic             step_emit;
    result_t          step_result;
    logic             advance;
    logic             process;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    elhp_step #(
        .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
    ) u_step (
        .frame          (frame_reg),
        .hdr_start      (hdr_start_reg),
        .offset         (offset_reg),
        .data_byte      (in_data_reg),
        .last_byte      (in_last_reg),
        .encap_length   (encap_len_reg),
        .frame_next     (frame_next),
        .hdr_start_next (hdr_start_next),
        .offset_next    (offset_next),
        .emit           (step_emit),
        .result         (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encap_len_reg <= 8'h00;
        end
        else if (cfg_we)
        begin
            encap_len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            frame_reg     <= FRAME_CLEAR;
            hdr_start_reg <= '0;
            offset_reg    <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= process && step_emit;
            end
            if (process)
            begin
                frame_reg     <= frame_next;
                hdr_start_reg <= hdr_start_next;
                offset_reg    <= offset_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (process && step_emit)
        begin
            res_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = res_reg.l3_kind;
    assign m_axis_tdata  = {1'b0, res_reg.error_code, res_reg.header_bytes,
                            res_reg.inner_vid, res_reg.outer_vlan_id, res_reg.ethertype};

`ifndef NO_ASSERTIONS
    // A processed last byte always returns the parser to the start of a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        process && in_last_reg |=> frame_reg.phase == PH_ETH && offset_reg == '0)
        else $error("frame context not cleared after last byte");

    // A finished frame cannot stay open past its last byte: it always reports.
    assert property (@(posedge clk) disable iff (!rst_n)
        process && in_last_reg && frame_reg.phase != PH_DONE |-> step_emit)
        else $error("frame ended without a result");

    // Error results carry no protocol and no header length.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res_reg.error_code != ERR_OK
        |-> res_reg.l3_kind == L3_NONE && res_reg.header_bytes == '0)
        else $error("error result with protocol or length");

    // A successful result always names a layer three protocol.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res_reg.error_code == ERR_OK |-> res_reg.l3_kind != L3_NONE)
        else $error("good result without a protocol");
`endif

endmodule

### design/elhp_step.sv
// Per-byte next-state and result logic of the link header parser.
// Purely combinational; depends on elhp_pkg.
module elhp_step
    import elhp_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF
)
(
    input  frame_state_t                                  frame,
    input  logic [$clog2(MAX_HEADER_BYTES + 2)-1:0]       hdr_start,
    input  logic [$clog2(MAX_HEADER_BYTES + 2)-1:0]       offset,
    input  logic [7:0]                                    data_byte,
    input  logic                                          last_byte,
    input  logic [7:0]                                    encap_length,
    output frame_state_t                                  frame_next,
    output logic [$clog2(MAX_HEADER_BYTES + 2)-1:0]       hdr_start_next,
    output logic [$clog2(MAX_HEADER_BYTES + 2)-1:0]       offset_next,
    output logic                                          emit,
    output result_t                                       result
);

    localparam int OFS_W = $clog2(MAX_HEADER_BYTES + 2);
    localparam int REL_W = (OFS_W > 9) ? OFS_W : 9;

    frame_state_t     upd;
    logic [OFS_W-1:0] upd_hs;
    logic [3:0]       err;
    logic             do_disp;
    logic             refeed;
    logic [REL_W-1:0] rel;
    logic [REL_W-1:0] enc_end;

    // Parse step: the current element, the dispatch on its type, and the
    // first byte of the element that starts at this same byte.
    always_comb
    begin
        upd     = frame;
        upd_hs  = hdr_start;
        emit    = 1'b0;
        err     = ERR_OK;
        do_disp = 1'b0;
        refeed  = 1'b0;
        rel     = REL_W'(offset) - REL_W'(hdr_start);
        enc_end = REL_W'(frame.enc_len) + REL_W'(20);

        if (frame.phase != PH_DONE)
        begin
            if (offset > OFS_W'(MAX_HEADER_BYTES))
            begin
                emit = 1'b1;
                err  = ERR_TOO_LONG;
            end
            else
            begin
                case (frame.phase)
                    PH_ETH:
                    begin
                        if (rel == REL_W'(12) || rel == REL_W'(13))
                        begin
                            upd.field_shift = {frame.field_shift[7:0], data_byte};
                        end
                        if (rel == REL_W'(13))
                        begin
                            upd.cur_type = upd.field_shift;
                            upd_hs       = OFS_W'(14);
                            if (upd.cur_type == ETH_FABRIC)
                            begin
                                upd.field_shift = '0;
                                upd.phase       = PH_FP;
                            end
                            else
                            begin
                                do_disp = 1'b1;
                            end
                        end
                    end
                    PH_FP:
                    begin
                        if (rel == REL_W'(14) || rel == REL_W'(15))
                        begin
                            upd.field_shift = {frame.field_shift[7:0], data_byte};
                        end
                        if (rel == REL_W'(16))
                        begin
                            upd.cur_type = upd.field_shift;
                            upd_hs       = offset;
                            do_disp      = 1'b1;
                            refeed       = 1'b1;
                        end
                    end
                    PH_VLAN:
                    begin
                        if (rel == REL_W'(0))
                        begin
                            upd.tag_vid = {8'h00, data_byte[3:0]};
                        end
                        else if (rel == REL_W'(1))
                        begin
                            upd.tag_vid = {frame.tag_vid[3:0], data_byte};
                        end
                        else if (rel == REL_W'(2) || rel == REL_W'(3))
                        begin
                            upd.field_shift = {frame.field_shift[7:0], data_byte};
                        end
                        if (rel == REL_W'(4))
                        begin
                            if (frame.vlan_seen)
                            begin
                                upd.inner_tag = frame.tag_vid;
                            end
                            else
                            begin
                                upd.outer_vlan = frame.tag_vid;
                            end
                            upd.vlan_seen = 1'b1;
                            upd.cur_type  = frame.field_shift;
                            upd_hs        = offset;
                            do_disp       = 1'b1;
                            refeed        = 1'b1;
                        end
                    end
                    PH_PPPOE:
                    begin
                        if (rel == REL_W'(6) || rel == REL_W'(7))
                        begin
                            upd.field_shift = {frame.field_shift[7:0], data_byte};
                        end
                        if (rel == REL_W'(8))
                        begin
                            upd.cur_type = frame.field_shift;
                            upd_hs       = offset;
                            if (frame.field_shift == PPP_IPV4)
                            begin
                                upd.proto_kind = L3_IPV4;
                                do_disp        = 1'b1;
                                refeed         = 1'b1;
                            end
                            else if (frame.field_shift == PPP_IPV6)
                            begin
                                upd.proto_kind = L3_IPV6;
                                do_disp        = 1'b1;
                                refeed         = 1'b1;
                            end
                            else
                            begin
                                emit = 1'b1;
                                err  = ERR_PPPOE_NONIP;
                            end
                        end
                    end
                    PH_MPLS:
                    begin
                        if (rel == REL_W'(2))
                        begin
                            upd.field_shift = {15'h0000, data_byte[0]};
                        end
                        if (rel == REL_W'(4))
                        begin
                            upd_hs = offset;
                            // Bottom of stack: the IP header starts right here.
                            if (frame.field_shift[0])
                            begin
                                upd.phase = PH_MPLS_IP;
                            end
                            upd.field_shift = '0;
                            refeed          = 1'b1;
                        end
                    end
                    PH_MPLS_IP:
                    begin
                        if (rel == REL_W'(0))
                        begin
                            upd.field_shift = {12'h000, data_byte[7:4]};
                        end
                        if (rel == REL_W'(20))
                        begin
                            upd.proto_kind = version_kind(upd.field_shift[3:0]);
                            emit           = 1'b1;
                            err = (upd.proto_kind == L3_NONE) ? ERR_MPLS_NO_IP : ERR_OK;
                        end
                    end
                    PH_ENCAP:
                    begin
                        if (rel == REL_W'(frame.enc_len))
                        begin
                            upd.field_shift = {12'h000, data_byte[7:4]};
                        end
                        if (rel == enc_end)
                        begin
                            upd_hs = OFS_W'(REL_W'(hdr_start) + REL_W'(frame.enc_len));
                            upd.proto_kind = version_kind(upd.field_shift[3:0]);
                            emit           = 1'b1;
                            err = (upd.proto_kind == L3_NONE) ? ERR_ENCAP_NO_IP : ERR_OK;
                        end
                    end
                    default:
                    begin
                        upd = frame;
                    end
                endcase

                if (do_disp)
                begin
                    upd.field_shift = '0;
                    if (upd.cur_type inside {ETH_VLAN_Q, ETH_VLAN_AD})
                    begin
                        upd.phase = PH_VLAN;
                    end
                    else if (upd.cur_type == ETH_PPPOE)
                    begin
                        upd.phase = PH_PPPOE;
                    end
                    else if (upd.cur_type == ETH_MPLS)
                    begin
                        upd.phase = PH_MPLS;
                    end
                    else
                    begin
                        if (upd.proto_kind == L3_NONE)
                        begin
                            if (upd.cur_type == ETH_IPV4)
                            begin
                                upd.proto_kind = L3_IPV4;
                            end
                            else if (upd.cur_type == ETH_IPV6)
                            begin
                                upd.proto_kind = L3_IPV6;
                            end
                            else if (upd.cur_type inside {ETH_ARP, ETH_RARP})
                            begin
                                upd.proto_kind = L3_ARP;
                            end
                            else
                            begin
                                emit = 1'b1;
                                err  = ERR_NON_IP;
                            end
                        end
                        if (!emit)
                        begin
                            if (encap_length != 8'h00)
                            begin
                                upd.enc_len = encap_length;
                                upd.phase   = PH_ENCAP;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                    end
                end

                // The byte that closes one element is also byte zero of the next.
                if (refeed && !emit)
                begin
                    if (upd.phase == PH_VLAN)
                    begin
                        upd.tag_vid = {8'h00, data_byte[3:0]};
                    end
                    else if (upd.phase == PH_MPLS_IP)
                    begin
                        upd.field_shift = {12'h000, data_byte[7:4]};
                    end
                end
            end

            if (!emit && last_byte && upd.phase != PH_DONE)
            begin
                emit = 1'b1;
                case (upd.phase)
                    PH_FP:      err = ERR_TRUNC_FP;
                    PH_MPLS_IP: err = ERR_MPLS_NO_IP;
                    PH_ENCAP:   err = ERR_ENCAP_SHORT;
                    default:    err = ERR_TRUNC_LINK;
                endcase
            end

            if (emit)
            begin
                upd.phase = PH_DONE;
            end
        end
    end

    always_comb
    begin
        result.l3_kind       = (err == ERR_OK) ? upd.proto_kind : L3_NONE;
        result.ethertype     = upd.cur_type;
        result.outer_vlan_id = upd.outer_vlan;
        result.inner_vid     = upd.inner_tag;
        result.header_bytes  = (err == ERR_OK) ? HB_W'(upd_hs) : '0;
        result.error_code    = err;
    end

    always_comb
    begin
        if (last_byte)
        begin
            frame_next     = FRAME_CLEAR;
            hdr_start_next = '0;
            offset_next    = '0;
        end
        else
        begin
            frame_next     = upd;
            hdr_start_next = upd_hs;
            offset_next    = (offset <= OFS_W'(MAX_HEADER_BYTES)) ? offset + OFS_W'(1) : offset;
        end
    end

endmodule
